[hdl/tcld_pkg.sv]
// shared types, constants and the arctangent table of the lock-in detector
package tcld_pkg;

  localparam int unsigned SAMPLE_BITS     = 12;
  localparam int unsigned CHANNELS        = 3;
  localparam int unsigned CH_W            = 2;
  localparam int unsigned REF_W           = 16;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned DIFF_W          = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W          = DIFF_W + REF_W;
  localparam int unsigned ACC_W           = 48;
  localparam int unsigned HALF_W          = ACC_W / 2;
  localparam int unsigned SQ_W            = 2 * ACC_W + 2;
  localparam int unsigned ROOT_W          = SQ_W / 2;
  localparam int unsigned AMP_W           = 28;
  localparam int unsigned PHASE_W         = 16;
  localparam int unsigned CORDIC_STEPS    = 22;
  localparam int unsigned ROT_W           = ACC_W + 4;
  localparam int unsigned ANG_W           = 26;
  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_NUM_PRESETS = 2;
  localparam logic [SAMPLE_BITS-1:0] OFFSET_RESET = SAMPLE_BITS'(2048);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic                    preset;
    logic [IDX_W-1:0]        ref_index;
    logic signed [REF_W-1:0] ref_cos;
    logic signed [REF_W-1:0] ref_sin;
    logic [SAMPLE_BITS-1:0]  sample_a;
    logic [SAMPLE_BITS-1:0]  sample_b;
    logic [SAMPLE_BITS-1:0]  sample_c;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]           channel;
    logic [AMP_W-1:0]          amplitude;
    logic signed [PHASE_W-1:0] phase;
    logic                      overrun;
    logic                      last_result;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic ack;
  } fin_ctl_t;

  function automatic logic [21:0] atan_units(input logic [4:0] k);
    logic [21:0] r;
    unique case (k)
      5'd0:    r = 22'd2097152;
      5'd1:    r = 22'd1238021;
      5'd2:    r = 22'd654136;
      5'd3:    r = 22'd332050;
      5'd4:    r = 22'd166669;
      5'd5:    r = 22'd83416;
      5'd6:    r = 22'd41718;
      5'd7:    r = 22'd20860;
      5'd8:    r = 22'd10430;
      5'd9:    r = 22'd5215;
      5'd10:   r = 22'd2608;
      5'd11:   r = 22'd1304;
      5'd12:   r = 22'd652;
      5'd13:   r = 22'd326;
      5'd14:   r = 22'd163;
      5'd15:   r = 22'd81;
      5'd16:   r = 22'd41;
      5'd17:   r = 22'd20;
      5'd18:   r = 22'd10;
      5'd19:   r = 22'd5;
      5'd20:   r = 22'd3;
      5'd21:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/tcld_ram.sv]
// generic single write, single read ram with registered read data
module tcld_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tcld_lane.sv]
// one channel lane: offset-removed sample times cosine and sine, into wide sums
module tcld_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [tcld_pkg::DIFF_W-1:0]  diff_i,
  input  logic signed [tcld_pkg::REF_W-1:0]   cos_i,
  input  logic signed [tcld_pkg::REF_W-1:0]   sin_i,
  input  logic                                mul_en_i,
  input  logic                                acc_en_i,
  input  logic                                clr_i,
  output logic signed [tcld_pkg::ACC_W-1:0]   i_sum_o,
  output logic signed [tcld_pkg::ACC_W-1:0]   q_sum_o
);

  logic signed [tcld_pkg::PROD_W-1:0] pc_q, ps_q;
  logic signed [tcld_pkg::ACC_W-1:0]  i_q, q_q;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      pc_q <= diff_i * cos_i;
      ps_q <= diff_i * sin_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      q_q <= '0;
    end else if (clr_i) begin
      i_q <= '0;
      q_q <= '0;
    end else if (acc_en_i) begin
      i_q <= i_q + tcld_pkg::ACC_W'(pc_q);
      q_q <= q_q + tcld_pkg::ACC_W'(ps_q);
    end
  end

  assign i_sum_o = i_q;
  assign q_sum_o = q_q;

endmodule

[hdl/tcld_finish.sv]
// shared finishing unit: magnitude by square root and division, phase by cordic
module tcld_finish #(
  parameter int unsigned CNT_W = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcld_pkg::fin_ctl_t                  ctl_i,
  input  logic signed [tcld_pkg::ACC_W-1:0]   i_sum_i,
  input  logic signed [tcld_pkg::ACC_W-1:0]   q_sum_i,
  input  logic [CNT_W-1:0]                    count_i,
  output logic                                done_o,
  output logic [tcld_pkg::AMP_W-1:0]          amplitude_o,
  output logic signed [tcld_pkg::PHASE_W-1:0] phase_o
);

  localparam int unsigned ACC_W  = tcld_pkg::ACC_W;
  localparam int unsigned HALF_W = tcld_pkg::HALF_W;
  localparam int unsigned SQ_W   = tcld_pkg::SQ_W;
  localparam int unsigned ROOT_W = tcld_pkg::ROOT_W;
  localparam int unsigned ROT_W  = tcld_pkg::ROT_W;
  localparam int unsigned ANG_W  = tcld_pkg::ANG_W;
  localparam int unsigned AMP_W  = tcld_pkg::AMP_W;
  localparam int unsigned REM_W  = ROOT_W + 3;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ   = 3'd1;
  localparam logic [2:0] F_ROOT = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_NORM = 3'd4;
  localparam logic [2:0] F_ROT  = 3'd5;
  localparam logic [2:0] F_DONE = 3'd6;

  localparam logic [5:0] SQ_LAST   = 6'd6;
  localparam logic [5:0] ROOT_LAST = 6'(ROOT_W - 1);
  localparam logic [5:0] ROT_LAST  = 6'(tcld_pkg::CORDIC_STEPS - 1);

  localparam logic signed [ROT_W-1:0] NORM_HI = ROT_W'(64'sd35184372088831);
  localparam logic signed [ROT_W-1:0] NORM_LO = -NORM_HI;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  logic [ACC_W-1:0]          mag_i_q, mag_q_q;
  logic [CNT_W-1:0]          n_q;
  logic [2*HALF_W-1:0]       prod_q;
  logic [6:0]                sh_q;
  logic [SQ_W-1:0]           acc_q;
  logic [REM_W-1:0]          rem_q;
  logic [ROOT_W-1:0]         root_q;
  logic [CNT_W-1:0]          drem_q;
  logic signed [ROT_W-1:0]   cx_q, cy_q;
  logic signed [ANG_W-1:0]   cz_q;
  logic                      base_q;

  logic [HALF_W-1:0]         mul_a, mul_b;
  logic [6:0]                mul_sh;
  logic [REM_W-1:0]          rem_n, trial;
  logic [CNT_W:0]            drem_n;
  logic                      below_norm;
  logic signed [ROT_W-1:0]   xs, ys;
  logic signed [ANG_W-1:0]   ang, zr;
  logic signed [ACC_W-1:0]   neg_i, neg_q;

  always_comb begin
    unique case (cnt_q)
      6'd0: begin
        mul_a  = mag_i_q[HALF_W-1:0];
        mul_b  = mag_i_q[HALF_W-1:0];
        mul_sh = 7'd2;
      end
      6'd1: begin
        mul_a  = mag_i_q[HALF_W-1:0];
        mul_b  = mag_i_q[ACC_W-1:HALF_W];
        mul_sh = 7'(HALF_W + 3);
      end
      6'd2: begin
        mul_a  = mag_i_q[ACC_W-1:HALF_W];
        mul_b  = mag_i_q[ACC_W-1:HALF_W];
        mul_sh = 7'(2 * HALF_W + 2);
      end
      6'd3: begin
        mul_a  = mag_q_q[HALF_W-1:0];
        mul_b  = mag_q_q[HALF_W-1:0];
        mul_sh = 7'd2;
      end
      6'd4: begin
        mul_a  = mag_q_q[HALF_W-1:0];
        mul_b  = mag_q_q[ACC_W-1:HALF_W];
        mul_sh = 7'(HALF_W + 3);
      end
      6'd5: begin
        mul_a  = mag_q_q[ACC_W-1:HALF_W];
        mul_b  = mag_q_q[ACC_W-1:HALF_W];
        mul_sh = 7'(2 * HALF_W + 2);
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = '0;
      end
    endcase
  end

  assign rem_n  = {rem_q[REM_W-3:0], acc_q[SQ_W-1:SQ_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign drem_n = {drem_q, root_q[ROOT_W-1]};
  assign below_norm = (cx_q >= NORM_LO) && (cx_q <= NORM_HI) &&
                      (cy_q >= NORM_LO) && (cy_q <= NORM_HI);
  assign xs     = cx_q >>> cnt_q[4:0];
  assign ys     = cy_q >>> cnt_q[4:0];
  assign ang    = ANG_W'(tcld_pkg::atan_units(cnt_q[4:0]));
  assign neg_i  = -i_sum_i;
  assign neg_q  = -q_sum_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (ctl_i.start) begin
          state_d = F_SQ;
          cnt_d   = '0;
        end
      end
      F_SQ: begin
        if (cnt_q == SQ_LAST) begin
          state_d = F_ROOT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      F_ROOT: begin
        if (cnt_q == ROOT_LAST) begin
          state_d = F_DIV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      F_DIV: begin
        if (cnt_q == ROOT_LAST) begin
          state_d = F_NORM;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      F_NORM: begin
        if (cy_q == '0) begin
          state_d = F_DONE;
        end else if (!below_norm) begin
          state_d = F_ROT;
          cnt_d   = '0;
        end
      end
      F_ROT: begin
        if (cnt_q == ROT_LAST) begin
          state_d = F_DONE;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      F_DONE: begin
        if (ctl_i.ack) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (ctl_i.start) begin
          mag_i_q <= i_sum_i[ACC_W-1] ? neg_i : i_sum_i;
          mag_q_q <= q_sum_i[ACC_W-1] ? neg_q : q_sum_i;
          n_q     <= count_i;
          acc_q   <= '0;
          rem_q   <= '0;
          root_q  <= '0;
          drem_q  <= '0;
          cz_q    <= '0;
          base_q  <= q_sum_i[ACC_W-1];
          if (q_sum_i[ACC_W-1]) begin
            cx_q <= -ROT_W'(q_sum_i);
            cy_q <= -ROT_W'(i_sum_i);
          end else begin
            cx_q <= ROT_W'(q_sum_i);
            cy_q <= ROT_W'(i_sum_i);
          end
        end
      end
      F_SQ: begin
        prod_q <= mul_a * mul_b;
        sh_q   <= mul_sh;
        if (cnt_q != '0) begin
          acc_q <= acc_q + (SQ_W'(prod_q) << sh_q);
        end
      end
      F_ROOT: begin
        acc_q <= acc_q << 2;
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      F_DIV: begin
        if (drem_n >= {1'b0, n_q}) begin
          drem_q <= CNT_W'(drem_n - {1'b0, n_q});
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          drem_q <= CNT_W'(drem_n);
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      F_NORM: begin
        if (cy_q != '0 && below_norm) begin
          cx_q <= cx_q <<< 1;
          cy_q <= cy_q <<< 1;
        end
      end
      F_ROT: begin
        if (cy_q >= 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + ang;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - ang;
        end
      end
      default: begin
      end
    endcase
  end

  assign zr     = (cz_q + ANG_W'(128)) >>> 8;
  assign done_o = (state_q == F_DONE);

  always_comb begin
    if (n_q == '0) begin
      amplitude_o = '0;
    end else if (root_q[ROOT_W-1:AMP_W] != '0) begin
      amplitude_o = '1;
    end else begin
      amplitude_o = root_q[AMP_W-1:0];
    end
  end

  assign phase_o = tcld_pkg::PHASE_W'(zr) + {base_q, 15'd0};

endmodule

[hdl/three_channel_lock_in_detector.sv]
// top level of the three channel quadrature lock-in detector
// A load item writes one cosine/sine pair into the reference memory and leaves the
// detector idle. A sample item reads the pair at the running index from the memory
// (one registered read port), multiplies in the three channel lanes and accumulates.
// An item marked last then runs each channel in turn through the shared finishing
// unit: squaring on one 24x24 multiplier, square root, division by the sample
// count, cordic normalization and cordic rotation (both skipped when the in-phase
// sum is zero).
// The input is stalled while an item is at work. The reference memory has no reset
// and needs no clearing pass; every entry must be loaded before a run reads it.
module three_channel_lock_in_detector #(
  parameter int unsigned TABLE_DEPTH = tcld_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned NUM_PRESETS = tcld_pkg::DEF_NUM_PRESETS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  tcld_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output tcld_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tcld_pkg::SAMPLE_BITS-1:0]     cfg_data_i
);

  localparam int unsigned TABLE_SIZE = NUM_PRESETS * TABLE_DEPTH;
  localparam int unsigned ADDR_W     = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CHANNELS   = tcld_pkg::CHANNELS;
  localparam int unsigned CH_W       = tcld_pkg::CH_W;
  localparam int unsigned REF_W      = tcld_pkg::REF_W;
  localparam int unsigned DIFF_W     = tcld_pkg::DIFF_W;
  localparam int unsigned ACC_W      = tcld_pkg::ACC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  logic [2:0]                           state_q, state_d;
  logic [tcld_pkg::SAMPLE_BITS-1:0]     off_q;
  logic [CNT_W-1:0]                     count_q;
  logic                                 overrun_q;
  logic                                 last_q;
  logic [CH_W-1:0]                      ch_q;
  logic                                 out_valid_q;
  tcld_pkg::out_item_t                  out_q;
  logic signed [DIFF_W-1:0]             diff_q [CHANNELS];

  logic                                 in_acc, out_take, is_load, is_sample;
  logic                                 preset_sel, idx_ok, has_room;
  logic [ADDR_W-1:0]                    base_addr, waddr, raddr;
  logic                                 we, re;
  logic [2*REF_W-1:0]                   rdata;
  logic                                 mul_en, acc_en, clr_run;
  logic [tcld_pkg::SAMPLE_BITS-1:0]     smp [CHANNELS];
  logic signed [ACC_W-1:0]              i_sum [CHANNELS];
  logic signed [ACC_W-1:0]              q_sum [CHANNELS];
  tcld_pkg::fin_ctl_t                   fin_ctl;
  logic                                 fin_done;
  logic [tcld_pkg::AMP_W-1:0]           fin_amp;
  logic signed [tcld_pkg::PHASE_W-1:0]  fin_phase;
  logic                                 out_load;

  assign smp[0] = in_data_i.sample_a;
  assign smp[1] = in_data_i.sample_b;
  assign smp[2] = in_data_i.sample_c;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign is_load    = in_acc && (in_data_i.kind == tcld_pkg::KIND_LOAD);
  assign is_sample  = in_acc && (in_data_i.kind == tcld_pkg::KIND_SAMPLE);
  assign preset_sel = (NUM_PRESETS > 1) ? in_data_i.preset : 1'b0;
  assign base_addr  = preset_sel ? ADDR_W'(TABLE_DEPTH) : '0;
  assign idx_ok     = (32'(in_data_i.ref_index) < TABLE_DEPTH);
  assign has_room   = (32'(count_q) < TABLE_DEPTH);
  assign waddr      = base_addr + ADDR_W'(in_data_i.ref_index);
  assign raddr      = base_addr + ADDR_W'(count_q);
  assign we         = is_load && idx_ok;
  assign re         = is_sample && has_room;

  tcld_ram #(
    .WIDTH (2 * REF_W),
    .DEPTH (TABLE_SIZE)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({in_data_i.ref_cos, in_data_i.ref_sin}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign mul_en  = (state_q == S_MUL);
  assign acc_en  = (state_q == S_ACC);
  assign out_load = (state_q == S_WAIT) && fin_done && (!out_valid_q || !out_stall_i);
  assign clr_run = out_load && (ch_q == CH_LAST);

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (is_sample) begin
        diff_q[g] <= $signed({1'b0, smp[g]}) - $signed({1'b0, off_q});
      end
    end

    tcld_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .diff_i   (diff_q[g]),
      .cos_i    (rdata[2*REF_W-1:REF_W]),
      .sin_i    (rdata[REF_W-1:0]),
      .mul_en_i (mul_en),
      .acc_en_i (acc_en),
      .clr_i    (clr_run),
      .i_sum_o  (i_sum[g]),
      .q_sum_o  (q_sum[g])
    );
  end

  assign fin_ctl.start = (state_q == S_FIN);
  assign fin_ctl.ack   = out_load;

  tcld_finish #(
    .CNT_W (CNT_W)
  ) u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (fin_ctl),
    .i_sum_i     (i_sum[ch_q]),
    .q_sum_i     (q_sum[ch_q]),
    .count_i     (count_q),
    .done_o      (fin_done),
    .amplitude_o (fin_amp),
    .phase_o     (fin_phase)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (is_sample) begin
          if (has_room) begin
            state_d = S_MUL;
          end else if (in_data_i.last) begin
            state_d = S_FIN;
          end
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (out_load) begin
          state_d = (ch_q == CH_LAST) ? S_IDLE : S_FIN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      off_q       <= tcld_pkg::OFFSET_RESET;
      count_q     <= '0;
      overrun_q   <= 1'b0;
      last_q      <= 1'b0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        off_q <= cfg_data_i;
      end
      if (is_sample) begin
        last_q <= in_data_i.last;
        if (!has_room) begin
          overrun_q <= 1'b1;
        end
      end
      if (acc_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        ch_q        <= (ch_q == CH_LAST) ? '0 : ch_q + CH_W'(1);
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (clr_run) begin
        count_q   <= '0;
        overrun_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.channel     <= ch_q;
      out_q.amplitude   <= fin_amp;
      out_q.phase       <= fin_phase;
      out_q.overrun     <= overrun_q;
      out_q.last_result <= (ch_q == CH_LAST);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
